@@ rtl/ocsdf_pkg.sv @@
// Shared constants and types for the octree SDF point query block.
package ocsdf_pkg;

    // Fixed field formats
    localparam int VALUE_BITS      = 16;
    localparam int COORD_FRAC_BITS = 24;
    localparam int POS_W           = COORD_FRAC_BITS + 1;
    localparam int OFS_W           = 12;
    localparam int NIDX_W          = 12;

    // Stream packing
    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 32;
    localparam int USER_W   = 2;

    // Interpolation datapath: three blend levels, each adds COORD_FRAC_BITS fraction bits
    localparam int ACC_W   = VALUE_BITS + 3 * COORD_FRAC_BITS + 1;
    localparam int DIFF_W  = ACC_W + 1;
    localparam int CHUNK_W = COORD_FRAC_BITS;
    localparam int PROD_W  = (CHUNK_W + 1) + (POS_W + 1);
    localparam int FLOOR_LSB = 3 * COORD_FRAC_BITS;

    // Operation codes (s_tuser)
    localparam logic [1:0] OP_WR_OFS = 2'd0;
    localparam logic [1:0] OP_WR_VAL = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Fault codes (m_tuser)
    localparam logic [1:0] FLT_OK    = 2'd0;
    localparam logic [1:0] FLT_DEPTH = 2'd1;
    localparam logic [1:0] FLT_RANGE = 2'd2;

    // Coordinate constants
    localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1) << COORD_FRAC_BITS;
    localparam logic [POS_W-1:0] POS_HALF = POS_W'(1) << (COORD_FRAC_BITS - 1);

    typedef logic [1:0] chunk_cnt_t;

    // Blend unit control
    typedef struct packed {
        logic       start;
        chunk_cnt_t last_chunk;
    } lerp_ctl_t;

endpackage

@@ rtl/ocsdf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ocsdf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ocsdf_lerp.sv @@
// Exact linear blend unit: result = a * 2^F + (b - a) * t, multiplied in 24-bit chunks.
module ocsdf_lerp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ocsdf_pkg::lerp_ctl_t                ctl,
    input  logic signed [ocsdf_pkg::ACC_W-1:0]  op_a,
    input  logic signed [ocsdf_pkg::ACC_W-1:0]  op_b,
    input  logic [ocsdf_pkg::POS_W-1:0]         weight,
    output logic                                done,
    output logic signed [ocsdf_pkg::ACC_W-1:0]  result
);
    import ocsdf_pkg::*;

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_MUL  = 2'd1;
    localparam logic [1:0] L_ACC  = 2'd2;

    logic [1:0]                state_reg, state_next;
    chunk_cnt_t                c_reg, c_next;
    chunk_cnt_t                last_reg, last_next;
    logic                      done_reg, done_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [DIFF_W-1:0]         diff_reg, diff_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [POS_W-1:0]          t_reg, t_next;

    logic [CHUNK_W:0]          chunk_raw;
    logic signed [CHUNK_W:0]   chunk_op;
    logic signed [POS_W:0]     t_op;
    logic [ACC_W-1:0]          prod_ext;
    logic [ACC_W-1:0]          addend;

    // Chunk of the difference for this step; the top chunk carries the sign
    always_comb begin
        unique case (c_reg)
            2'd0:    chunk_raw = diff_reg[0 +: CHUNK_W + 1];
            2'd1:    chunk_raw = diff_reg[CHUNK_W +: CHUNK_W + 1];
            default: chunk_raw = diff_reg[2 * CHUNK_W +: CHUNK_W + 1];
        endcase
        if (c_reg == last_reg) begin
            chunk_op = $signed(chunk_raw);
        end else begin
            chunk_op = $signed({1'b0, chunk_raw[CHUNK_W-1:0]});
        end
        t_op = $signed({1'b0, t_reg});
    end

    // Shift the registered partial product into place
    always_comb begin
        prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        unique case (c_reg)
            2'd0:    addend = prod_ext;
            2'd1:    addend = prod_ext << CHUNK_W;
            default: addend = prod_ext << (2 * CHUNK_W);
        endcase
    end

    // Sequencer: start, then multiply / accumulate per chunk
    always_comb begin
        state_next = state_reg;
        c_next     = c_reg;
        last_next  = last_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        diff_next  = diff_reg;
        prod_next  = prod_reg;
        t_next     = t_reg;
        unique case (state_reg)
            L_IDLE: begin
                if (ctl.start) begin
                    acc_next   = op_a <<< COORD_FRAC_BITS;
                    diff_next  = {op_b[ACC_W-1], op_b} - {op_a[ACC_W-1], op_a};
                    t_next     = weight;
                    c_next     = '0;
                    last_next  = ctl.last_chunk;
                    state_next = L_MUL;
                end
            end
            L_MUL: begin
                prod_next  = chunk_op * t_op;
                state_next = L_ACC;
            end
            L_ACC: begin
                acc_next = $signed(ACC_W'(acc_reg + addend));
                if (c_reg == last_reg) begin
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end else begin
                    c_next     = c_reg + 2'd1;
                    state_next = L_MUL;
                end
            end
            default: begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        c_reg    <= c_next;
        last_reg <= last_next;
        acc_reg  <= acc_next;
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        t_reg    <= t_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

@@ rtl/octree_sdf_point_query.sv @@
// Octree SDF point query: node table RAMs, descent sequencer and trilinear blend.
//
//  channel | dir | tdata                                          | tuser
//  s_      | in  | load / query item, 120 bits                    | op
//  m_      | out | inside_res, sampled_value, leaf_node, 32 bits  | fault
//
// A load item is written to its table when accepted. A query does one offset RAM read
// per level descended, eight corner RAM reads, then seven blends on the shared chunked
// multiplier; no new item is taken while a query runs.
// Reset is synchronous and clears control only; table contents are undefined until written.
// The next item is taken while a result waits in the output register; a query that
// finishes while that register is still full holds until m_tready.
module octree_sdf_point_query #(
    parameter int NODE_COUNT = 4096,
    parameter int MAX_DEPTH  = 12
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [11:0] node_index, [14:12] corner, [26:15] child_offset, [42:27] corner_value,
    // [67:43] pos_x, [92:68] pos_y, [117:93] pos_z, [119:118] zero
    input  logic [ocsdf_pkg::S_DATA_W-1:0]     s_tdata,
    // [1:0] op
    input  logic [ocsdf_pkg::USER_W-1:0]       s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] inside_res, [16:1] sampled_value, [28:17] leaf_node, [31:29] zero
    output logic [ocsdf_pkg::M_DATA_W-1:0]     m_tdata,
    // [1:0] fault
    output logic [ocsdf_pkg::USER_W-1:0]       m_tuser
);
    import ocsdf_pkg::*;

    localparam int IDX_W   = $clog2(NODE_COUNT);
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int QN      = 8;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DESC  = 3'd1;
    localparam logic [2:0] S_CRD   = 3'd2;
    localparam logic [2:0] S_BLEND = 3'd3;
    localparam logic [2:0] S_BWAIT = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Input field decode
    logic [1:0]            in_op;
    logic [NIDX_W-1:0]     in_node;
    logic [2:0]            in_corner;
    logic [OFS_W-1:0]      in_ofs;
    logic [VALUE_BITS-1:0] in_val;
    logic [POS_W-1:0]      in_px, in_py, in_pz;

    assign in_op     = s_tuser[1:0];
    assign in_node   = s_tdata[11:0];
    assign in_corner = s_tdata[14:12];
    assign in_ofs    = s_tdata[26:15];
    assign in_val    = s_tdata[42:27];
    assign in_px     = s_tdata[67:43];
    assign in_py     = s_tdata[92:68];
    assign in_pz     = s_tdata[117:93];

    // State
    logic [2:0]              state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [DEPTH_W-1:0]      depth_reg, depth_next;
    logic [POS_W-1:0]        px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic [1:0]              fault_reg, fault_next;
    logic [3:0]              cnt_reg, cnt_next;
    logic [2:0]              blend_reg, blend_next;
    logic signed [ACC_W-1:0] q_reg [QN];
    logic signed [ACC_W-1:0] q_next [QN];
    logic                    m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]     m_data_reg, m_data_next;
    logic [USER_W-1:0]       m_user_reg, m_user_next;

    logic                    s_xfer;
    logic                    node_ok;
    logic                    out_free;

    // RAM ports
    logic                    ofs_we;
    logic [IDX_W-1:0]        ofs_raddr;
    logic [OFS_W-1:0]        ofs_rdata;
    logic                    crn_we;
    logic [IDX_W+2:0]        crn_waddr;
    logic [IDX_W+2:0]        crn_raddr;
    logic [VALUE_BITS-1:0]   crn_rdata;

    // Descent step
    logic                    gx, gy, gz;
    logic [2:0]              oct;
    logic [OFS_W:0]          child;
    logic                    child_ok;

    // Blend unit
    lerp_ctl_t               lerp_ctl;
    logic                    lerp_done;
    logic signed [ACC_W-1:0] lerp_res;
    logic [POS_W-1:0]        lerp_w;
    logic [2:0]              wpos;

    // Result fields
    logic                    res_inside;
    logic [VALUE_BITS-1:0]   res_value;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign node_ok  = 32'(in_node) < 32'(NODE_COUNT);
    assign out_free = !m_valid_reg || m_tready;

    // Table loads happen only on accepted load items
    assign ofs_we    = s_xfer && (in_op == OP_WR_OFS) && node_ok;
    assign crn_we    = s_xfer && (in_op == OP_WR_VAL) && node_ok;
    assign crn_waddr = {IDX_W'(in_node), in_corner};
    assign crn_raddr = {idx_reg, cnt_reg[2:0]};

    ocsdf_ram #(
        .WIDTH (OFS_W),
        .DEPTH (NODE_COUNT)
    ) u_ofs_ram (
        .aclk  (aclk),
        .we    (ofs_we),
        .waddr (IDX_W'(in_node)),
        .wdata (in_ofs),
        .raddr (ofs_raddr),
        .rdata (ofs_rdata)
    );

    ocsdf_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (NODE_COUNT * 8)
    ) u_crn_ram (
        .aclk  (aclk),
        .we    (crn_we),
        .waddr (crn_waddr),
        .wdata (in_val),
        .raddr (crn_raddr),
        .rdata (crn_rdata)
    );

    // Octant pick and child address from the offset just read
    always_comb begin
        gx       = px_reg > POS_HALF;
        gy       = py_reg > POS_HALF;
        gz       = pz_reg > POS_HALF;
        oct      = {gx, gy, gz};
        child    = {1'b0, ofs_rdata} + {{(OFS_W - 2){1'b0}}, oct};
        child_ok = 32'(child) < 32'(NODE_COUNT);
        if (state_reg == S_IDLE) begin
            ofs_raddr = '0;
        end else begin
            ofs_raddr = IDX_W'(child);
        end
    end

    // Blend level: four z blends, two y blends, one x blend
    always_comb begin
        lerp_ctl.start = (state_reg == S_BLEND);
        if (blend_reg < 3'd4) begin
            lerp_ctl.last_chunk = 2'd0;
            lerp_w              = pz_reg;
        end else if (blend_reg < 3'd6) begin
            lerp_ctl.last_chunk = 2'd1;
            lerp_w              = py_reg;
        end else begin
            lerp_ctl.last_chunk = 2'd2;
            lerp_w              = px_reg;
        end
        wpos = 3'd6 - blend_reg;
    end

    ocsdf_lerp u_lerp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lerp_ctl),
        .op_a    (q_reg[0]),
        .op_b    (q_reg[1]),
        .weight  (lerp_w),
        .done    (lerp_done),
        .result  (lerp_res)
    );

    // Final value sits in the head of the operand queue
    always_comb begin
        if (fault_reg == FLT_OK) begin
            res_inside = q_reg[0][ACC_W-1] || (q_reg[0] == '0);
            res_value  = q_reg[0][FLOOR_LSB +: VALUE_BITS];
        end else begin
            res_inside = 1'b0;
            res_value  = '0;
        end
    end

    // Main sequencer
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        depth_next   = depth_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pz_next      = pz_reg;
        fault_next   = fault_reg;
        cnt_next     = cnt_reg;
        blend_next   = blend_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_valid_next = m_valid_reg && !m_tready;
        for (int i = 0; i < QN; i++) begin
            q_next[i] = q_reg[i];
        end

        unique case (state_reg)
            S_IDLE: begin
                // Query starts at the root; its offset read goes out this cycle
                if (s_xfer && (in_op == OP_QUERY)) begin
                    idx_next   = '0;
                    depth_next = '0;
                    px_next    = (in_px > POS_ONE) ? POS_ONE : in_px;
                    py_next    = (in_py > POS_ONE) ? POS_ONE : in_py;
                    pz_next    = (in_pz > POS_ONE) ? POS_ONE : in_pz;
                    state_next = S_DESC;
                end
            end
            S_DESC: begin
                priority if (ofs_rdata == '0) begin
                    cnt_next   = '0;
                    state_next = S_CRD;
                end else if (depth_reg >= DEPTH_W'(MAX_DEPTH)) begin
                    fault_next = FLT_DEPTH;
                    state_next = S_DONE;
                end else if (!child_ok) begin
                    fault_next = FLT_RANGE;
                    state_next = S_DONE;
                end else begin
                    idx_next   = IDX_W'(child);
                    depth_next = depth_reg + DEPTH_W'(1);
                    px_next    = gx ? POS_W'((px_reg - POS_HALF) << 1) : POS_W'(px_reg << 1);
                    py_next    = gy ? POS_W'((py_reg - POS_HALF) << 1) : POS_W'(py_reg << 1);
                    pz_next    = gz ? POS_W'((pz_reg - POS_HALF) << 1) : POS_W'(pz_reg << 1);
                end
            end
            S_CRD: begin
                // Corner k is read at count k and lands in the next cycle
                if (cnt_reg != 4'd0) begin
                    for (int i = 0; i < QN; i++) begin
                        if (4'(i) == cnt_reg - 4'd1) begin
                            q_next[i] = $signed({{(ACC_W - VALUE_BITS){crn_rdata[VALUE_BITS-1]}},
                                                 crn_rdata});
                        end
                    end
                end
                if (cnt_reg == 4'd8) begin
                    blend_next = '0;
                    state_next = S_BLEND;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_BLEND: begin
                state_next = S_BWAIT;
            end
            S_BWAIT: begin
                // Pop the pair at the head, append the blend behind the remaining entries
                if (lerp_done) begin
                    for (int i = 0; i < QN - 2; i++) begin
                        q_next[i] = q_reg[i + 2];
                    end
                    for (int i = 0; i < QN; i++) begin
                        if (3'(i) == wpos) begin
                            q_next[i] = lerp_res;
                        end
                    end
                    if (blend_reg == 3'd6) begin
                        fault_next = FLT_OK;
                        state_next = S_DONE;
                    end else begin
                        blend_next = blend_reg + 3'd1;
                        state_next = S_BLEND;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, NIDX_W'(idx_reg), res_value, res_inside};
                    m_user_next  = fault_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg    <= idx_next;
        depth_reg  <= depth_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        pz_reg     <= pz_next;
        fault_reg  <= fault_next;
        cnt_reg    <= cnt_next;
        blend_reg  <= blend_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        for (int i = 0; i < QN; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

@@ rtl/ocsdf_chk.sv @@
// Port-level checker for the octree SDF point query block, bound to the top level.
module ocsdf_chk (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ocsdf_pkg::M_DATA_W-1:0] m_tdata,
    input logic [ocsdf_pkg::USER_W-1:0]   m_tuser
);
    import ocsdf_pkg::*;

    // Result register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A faulted query carries a known fault code, no distance and a clear inside flag
    a_fault_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != FLT_OK) |->
            (m_tuser == FLT_DEPTH || m_tuser == FLT_RANGE) && (m_tdata[16:0] == '0))
        else $error("bad fault code or nonzero payload on fault");

    // Inside flag agrees with the sign of the floored value
    a_inside_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == FLT_OK) |->
            (m_tdata[0] == (m_tdata[16] || (m_tdata[16:1] == '0))) || (m_tdata[16:1] == '0))
        else $error("inside flag disagrees with sampled value");

endmodule

bind octree_sdf_point_query ocsdf_chk u_ocsdf_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
